[sv/abt_pkg.sv]
// shared types and constants for the affine box transform core
// no dependencies; compiled first
package abt_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    // products, sums and determinant partial widths
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int COF_W  = PROD_W + 1;
    localparam int CHI_W  = COF_W - VALUE_WIDTH;
    localparam int PP_W   = VALUE_WIDTH + CHI_W;
    localparam int PP3_W  = PP_W + 2;
    localparam int DET_W  = PP3_W + VALUE_WIDTH;
    localparam int TSC_W  = VALUE_WIDTH + FRACTION_BITS;

    localparam int NSTAGE = 6;

    localparam logic [FRACTION_BITS-1:0] ROUND_HALF =
        FRACTION_BITS'(1) << (FRACTION_BITS - 1);
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MAX_X = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MAX_Y = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] mat_r0_c0;
        logic signed [VALUE_WIDTH-1:0] mat_r0_c1;
        logic signed [VALUE_WIDTH-1:0] mat_r0_c2;
        logic signed [VALUE_WIDTH-1:0] mat_r1_c0;
        logic signed [VALUE_WIDTH-1:0] mat_r1_c1;
        logic signed [VALUE_WIDTH-1:0] mat_r1_c2;
        logic signed [VALUE_WIDTH-1:0] mat_r2_c0;
        logic signed [VALUE_WIDTH-1:0] mat_r2_c1;
        logic signed [VALUE_WIDTH-1:0] mat_r2_c2;
        logic signed [VALUE_WIDTH-1:0] shift_x;
        logic signed [VALUE_WIDTH-1:0] shift_y;
        logic signed [VALUE_WIDTH-1:0] shift_z;
    } t_abt_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] world_min_x;
        logic signed [VALUE_WIDTH-1:0] world_min_y;
        logic signed [VALUE_WIDTH-1:0] world_min_z;
        logic signed [VALUE_WIDTH-1:0] world_max_x;
        logic signed [VALUE_WIDTH-1:0] world_max_y;
        logic signed [VALUE_WIDTH-1:0] world_max_z;
        logic                          mirrored;
        logic                          bounds_error;
    } t_abt_out_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] local_min_x;
        logic signed [VALUE_WIDTH-1:0] local_min_y;
        logic signed [VALUE_WIDTH-1:0] local_min_z;
        logic signed [VALUE_WIDTH-1:0] local_max_x;
        logic signed [VALUE_WIDTH-1:0] local_max_y;
        logic signed [VALUE_WIDTH-1:0] local_max_z;
    } t_abt_box;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] world_min_x;
        logic signed [VALUE_WIDTH-1:0] world_min_y;
        logic signed [VALUE_WIDTH-1:0] world_min_z;
        logic signed [VALUE_WIDTH-1:0] world_max_x;
        logic signed [VALUE_WIDTH-1:0] world_max_y;
        logic signed [VALUE_WIDTH-1:0] world_max_z;
        logic                          bounds_error;
    } t_abt_bnd_res;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } t_abt_pipe_ctl;

endpackage

[sv/abt_in_if.sv]
// input channel: transform items with valid/ready
// depends on abt_pkg
interface abt_in_if;
    import abt_pkg::*;

    logic         valid;
    logic         ready;
    t_abt_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/abt_out_if.sv]
// output channel: world box results with valid/ready
// depends on abt_pkg
interface abt_out_if;
    import abt_pkg::*;

    logic          valid;
    logic          ready;
    t_abt_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/affine_bounds_transform_core.sv]
// top level of the affine box transform: config registers, pipeline control,
// bound and determinant datapaths, output stage; depends on abt_pkg and the channel interfaces
//
//  channel   dir  handshake          contents
//  i_in      in   valid/ready        3x3 linear part and translation, Q16.16
//  o_out     out  valid/ready        world box min/max, mirrored, bounds_error
//  i_cfg_*   in   write enable only  local box min/max, index 0..5
//
// one transform per cycle sustained while o_out.ready is high; a result passes through
// the six register stages (the determinant path needs split 32x33 partial products).
// reset clears the valid bits and sets all local bounds to zero.
// a stage holds while its successor is full and stalled; empty stages close up,
// so i_in.ready drops only when all six stages hold items and o_out.ready is low.
module affine_bounds_transform_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    abt_in_if.sink                          i_in,
    abt_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [abt_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [abt_pkg::VALUE_WIDTH-1:0] i_cfg_data
);
    import abt_pkg::*;

    t_abt_box      box;
    t_abt_pipe_ctl ctl;
    t_abt_bnd_res  bnd;
    logic          in_ready;
    logic          mirrored;
    t_abt_out_item r_out;
    t_abt_out_item n_out;

    abt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_box       (box)
    );

    abt_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_ctl       (ctl)
    );

    abt_bounds_dp u_bounds (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_item (i_in.payload),
        .i_box  (box),
        .o_res  (bnd)
    );

    abt_det_dp u_det (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_item     (i_in.payload),
        .o_mirrored (mirrored)
    );

    // stage 6: output register
    always_comb begin
        n_out.world_min_x  = bnd.world_min_x;
        n_out.world_min_y  = bnd.world_min_y;
        n_out.world_min_z  = bnd.world_min_z;
        n_out.world_max_x  = bnd.world_max_x;
        n_out.world_max_y  = bnd.world_max_y;
        n_out.world_max_z  = bnd.world_max_z;
        n_out.mirrored     = mirrored;
        n_out.bounds_error = bnd.bounds_error;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[NSTAGE-1]) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = ctl.vld[NSTAGE-1];
    assign o_out.payload = r_out;

endmodule

[sv/abt_cfg_regs.sv]
// local box bound registers with a plain write port
// depends on abt_pkg
module abt_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abt_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [abt_pkg::VALUE_WIDTH-1:0]  i_cfg_data,
    output abt_pkg::t_abt_box                o_box
);
    import abt_pkg::*;

    t_abt_box r_box;
    t_abt_box n_box;

    always_comb begin
        n_box = r_box;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOCAL_MIN_X: n_box.local_min_x = i_cfg_data;
                CFG_LOCAL_MIN_Y: n_box.local_min_y = i_cfg_data;
                CFG_LOCAL_MIN_Z: n_box.local_min_z = i_cfg_data;
                CFG_LOCAL_MAX_X: n_box.local_max_x = i_cfg_data;
                CFG_LOCAL_MAX_Y: n_box.local_max_y = i_cfg_data;
                CFG_LOCAL_MAX_Z: n_box.local_max_z = i_cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

[sv/abt_pipe_ctrl.sv]
// valid bits and load enables for the six stage pipeline
// depends on abt_pkg
module abt_pipe_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output abt_pkg::t_abt_pipe_ctl o_ctl
);
    import abt_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = en[0];
    assign o_ctl.en   = en;
    assign o_ctl.vld  = r_vld;

`ifndef SYNTH
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_vld) && !i_out_ready))
        else $error("input blocked while pipeline has room");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-1] && !i_out_ready) |=> r_vld[NSTAGE-1])
        else $error("pending result dropped");

    a_entry_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted item not captured in first stage");

    a_stalled_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !en[1]) |=> r_vld[1])
        else $error("stalled stage lost its item");
`endif

endmodule

[sv/abt_bounds_dp.sv]
// box bound datapath: products, min/max select, row sums, rounding and saturation
// depends on abt_pkg; stages 1 to 5, enables from abt_pipe_ctrl
module abt_bounds_dp (
    input  logic                   i_clk,
    input  abt_pkg::t_abt_pipe_ctl i_ctl,
    input  abt_pkg::t_abt_in_item  i_item,
    input  abt_pkg::t_abt_box      i_box,
    output abt_pkg::t_abt_bnd_res  o_res
);
    import abt_pkg::*;

    function automatic logic signed [VALUE_WIDTH-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0]     sh;
        logic [SUM_W-VALUE_WIDTH:0]  top;
        sh  = v >>> FRACTION_BITS;
        top = sh[SUM_W-1:VALUE_WIDTH-1];
        if ((&top) || !(|top)) begin
            return sh[VALUE_WIDTH-1:0];
        end else if (sh[SUM_W-1]) begin
            return VAL_MIN;
        end else begin
            return VAL_MAX;
        end
    endfunction

    logic signed [VALUE_WIDTH-1:0] m  [9];
    logic signed [VALUE_WIDTH-1:0] lo [3];
    logic signed [VALUE_WIDTH-1:0] hi [3];
    logic signed [VALUE_WIDTH-1:0] t  [3];

    assign m[0] = i_item.mat_r0_c0;
    assign m[1] = i_item.mat_r0_c1;
    assign m[2] = i_item.mat_r0_c2;
    assign m[3] = i_item.mat_r1_c0;
    assign m[4] = i_item.mat_r1_c1;
    assign m[5] = i_item.mat_r1_c2;
    assign m[6] = i_item.mat_r2_c0;
    assign m[7] = i_item.mat_r2_c1;
    assign m[8] = i_item.mat_r2_c2;
    assign t[0] = i_item.shift_x;
    assign t[1] = i_item.shift_y;
    assign t[2] = i_item.shift_z;
    assign lo[0] = i_box.local_min_x;
    assign lo[1] = i_box.local_min_y;
    assign lo[2] = i_box.local_min_z;
    assign hi[0] = i_box.local_max_x;
    assign hi[1] = i_box.local_max_y;
    assign hi[2] = i_box.local_max_z;

    // stage 1: both products per matrix entry
    logic signed [PROD_W-1:0]      r_s1_plo [9];
    logic signed [PROD_W-1:0]      r_s1_phi [9];
    logic signed [PROD_W-1:0]      n_s1_plo [9];
    logic signed [PROD_W-1:0]      n_s1_phi [9];
    logic signed [VALUE_WIDTH-1:0] r_s1_t   [3];
    logic                          r_s1_err;
    logic                          n_s1_err;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_s1_plo[r*3+c] = m[r*3+c] * lo[c];
                n_s1_phi[r*3+c] = m[r*3+c] * hi[c];
            end
        end
        n_s1_err = (hi[0] < lo[0]) || (hi[1] < lo[1]) || (hi[2] < lo[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_plo <= n_s1_plo;
            r_s1_phi <= n_s1_phi;
            r_s1_t   <= t;
            r_s1_err <= n_s1_err;
        end
    end

    // stage 2: order each product pair
    logic signed [PROD_W-1:0]      r_s2_min [9];
    logic signed [PROD_W-1:0]      r_s2_max [9];
    logic signed [PROD_W-1:0]      n_s2_min [9];
    logic signed [PROD_W-1:0]      n_s2_max [9];
    logic signed [VALUE_WIDTH-1:0] r_s2_t   [3];
    logic                          r_s2_err;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (r_s1_phi[i] < r_s1_plo[i]) begin
                n_s2_min[i] = r_s1_phi[i];
                n_s2_max[i] = r_s1_plo[i];
            end else begin
                n_s2_min[i] = r_s1_plo[i];
                n_s2_max[i] = r_s1_phi[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_s2_min <= n_s2_min;
            r_s2_max <= n_s2_max;
            r_s2_t   <= r_s1_t;
            r_s2_err <= r_s1_err;
        end
    end

    // stage 3: partial row sums, translation scaled with the rounding half folded in
    logic signed [PROD_W:0] r_s3_lo01 [3];
    logic signed [PROD_W:0] r_s3_lo2t [3];
    logic signed [PROD_W:0] r_s3_hi01 [3];
    logic signed [PROD_W:0] r_s3_hi2t [3];
    logic signed [PROD_W:0] n_s3_lo01 [3];
    logic signed [PROD_W:0] n_s3_lo2t [3];
    logic signed [PROD_W:0] n_s3_hi01 [3];
    logic signed [PROD_W:0] n_s3_hi2t [3];
    logic signed [TSC_W-1:0] tsc      [3];
    logic                   r_s3_err;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            tsc[r] = $signed({r_s2_t[r], ROUND_HALF});
            n_s3_lo01[r] = (PROD_W+1)'(r_s2_min[r*3]) + (PROD_W+1)'(r_s2_min[r*3+1]);
            n_s3_lo2t[r] = (PROD_W+1)'(r_s2_min[r*3+2]) + (PROD_W+1)'(tsc[r]);
            n_s3_hi01[r] = (PROD_W+1)'(r_s2_max[r*3]) + (PROD_W+1)'(r_s2_max[r*3+1]);
            n_s3_hi2t[r] = (PROD_W+1)'(r_s2_max[r*3+2]) + (PROD_W+1)'(tsc[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s3_lo01 <= n_s3_lo01;
            r_s3_lo2t <= n_s3_lo2t;
            r_s3_hi01 <= n_s3_hi01;
            r_s3_hi2t <= n_s3_hi2t;
            r_s3_err  <= r_s2_err;
        end
    end

    // stage 4: full row sums
    logic signed [SUM_W-1:0] r_s4_lo [3];
    logic signed [SUM_W-1:0] r_s4_hi [3];
    logic signed [SUM_W-1:0] n_s4_lo [3];
    logic signed [SUM_W-1:0] n_s4_hi [3];
    logic                    r_s4_err;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s4_lo[r] = SUM_W'(r_s3_lo01[r]) + SUM_W'(r_s3_lo2t[r]);
            n_s4_hi[r] = SUM_W'(r_s3_hi01[r]) + SUM_W'(r_s3_hi2t[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_s4_lo  <= n_s4_lo;
            r_s4_hi  <= n_s4_hi;
            r_s4_err <= r_s3_err;
        end
    end

    // stage 5: drop fraction bits and clamp
    logic signed [VALUE_WIDTH-1:0] r_s5_lo [3];
    logic signed [VALUE_WIDTH-1:0] r_s5_hi [3];
    logic signed [VALUE_WIDTH-1:0] n_s5_lo [3];
    logic signed [VALUE_WIDTH-1:0] n_s5_hi [3];
    logic                          r_s5_err;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s5_lo[r] = round_sat(r_s4_lo[r]);
            n_s5_hi[r] = round_sat(r_s4_hi[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_s5_lo  <= n_s5_lo;
            r_s5_hi  <= n_s5_hi;
            r_s5_err <= r_s4_err;
        end
    end

    assign o_res.world_min_x  = r_s5_lo[0];
    assign o_res.world_min_y  = r_s5_lo[1];
    assign o_res.world_min_z  = r_s5_lo[2];
    assign o_res.world_max_x  = r_s5_hi[0];
    assign o_res.world_max_y  = r_s5_hi[1];
    assign o_res.world_max_z  = r_s5_hi[2];
    assign o_res.bounds_error = r_s5_err;

endmodule

[sv/abt_det_dp.sv]
// exact determinant sign: cofactors, split partial products, staged sums
// depends on abt_pkg; stages 1 to 5, final sign is combinational into the output stage
module abt_det_dp (
    input  logic                   i_clk,
    input  abt_pkg::t_abt_pipe_ctl i_ctl,
    input  abt_pkg::t_abt_in_item  i_item,
    output logic                   o_mirrored
);
    import abt_pkg::*;

    // stage 1: 2x2 minor products of rows 1 and 2
    logic signed [PROD_W-1:0]      r_s1_p   [6];
    logic signed [PROD_W-1:0]      n_s1_p   [6];
    logic signed [VALUE_WIDTH-1:0] row0     [3];
    logic signed [VALUE_WIDTH-1:0] r_s1_row [3];

    assign row0[0] = i_item.mat_r0_c0;
    assign row0[1] = i_item.mat_r0_c1;
    assign row0[2] = i_item.mat_r0_c2;

    always_comb begin
        n_s1_p[0] = i_item.mat_r1_c1 * i_item.mat_r2_c2;
        n_s1_p[1] = i_item.mat_r1_c2 * i_item.mat_r2_c1;
        // middle cofactor taken with its sign flipped so all terms add
        n_s1_p[2] = i_item.mat_r1_c2 * i_item.mat_r2_c0;
        n_s1_p[3] = i_item.mat_r1_c0 * i_item.mat_r2_c2;
        n_s1_p[4] = i_item.mat_r1_c0 * i_item.mat_r2_c1;
        n_s1_p[5] = i_item.mat_r1_c1 * i_item.mat_r2_c0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_p   <= n_s1_p;
            r_s1_row <= row0;
        end
    end

    // stage 2: cofactors
    logic signed [COF_W-1:0]       r_s2_cof [3];
    logic signed [COF_W-1:0]       n_s2_cof [3];
    logic signed [VALUE_WIDTH-1:0] r_s2_row [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_cof[k] = COF_W'(r_s1_p[2*k]) - COF_W'(r_s1_p[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_s2_cof <= n_s2_cof;
            r_s2_row <= r_s1_row;
        end
    end

    // stage 3: row 0 times cofactor, split into low unsigned and high signed halves
    logic signed [PP_W-1:0] r_s3_pl [3];
    logic signed [PP_W-1:0] r_s3_ph [3];
    logic signed [PP_W-1:0] n_s3_pl [3];
    logic signed [PP_W-1:0] n_s3_ph [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s3_pl[k] = r_s2_row[k] * $signed({1'b0, r_s2_cof[k][VALUE_WIDTH-1:0]});
            n_s3_ph[k] = r_s2_row[k] * $signed(r_s2_cof[k][COF_W-1:VALUE_WIDTH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s3_pl <= n_s3_pl;
            r_s3_ph <= n_s3_ph;
        end
    end

    // stage 4: first pair of each half summed
    logic signed [PP_W:0]   r_s4_pl01;
    logic signed [PP_W:0]   r_s4_ph01;
    logic signed [PP_W-1:0] r_s4_pl2;
    logic signed [PP_W-1:0] r_s4_ph2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_s4_pl01 <= (PP_W+1)'(r_s3_pl[0]) + (PP_W+1)'(r_s3_pl[1]);
            r_s4_ph01 <= (PP_W+1)'(r_s3_ph[0]) + (PP_W+1)'(r_s3_ph[1]);
            r_s4_pl2  <= r_s3_pl[2];
            r_s4_ph2  <= r_s3_ph[2];
        end
    end

    // stage 5: both halves complete
    logic signed [PP3_W-1:0] r_s5_lo;
    logic signed [PP3_W-1:0] r_s5_hi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_s5_lo <= PP3_W'(r_s4_pl01) + PP3_W'(r_s4_pl2);
            r_s5_hi <= PP3_W'(r_s4_ph01) + PP3_W'(r_s4_ph2);
        end
    end

    // recombine halves; only the sign is kept
    logic signed [DET_W-1:0] det;

    assign det        = $signed({r_s5_hi, {VALUE_WIDTH{1'b0}}}) + DET_W'(r_s5_lo);
    assign o_mirrored = det[DET_W-1];

endmodule
